[src/arb_pkg.sv]
// ----------------------------------------------------------------------------
// arb_pkg: shared definitions for the aliased register bank
// Operation codes, register bank geometry, alias identifiers and the write
// command that the access decoder hands to the register file.
// ----------------------------------------------------------------------------
`default_nettype none

package arb_pkg;

    localparam int unsigned NumRegs = 14;
    localparam int unsigned RegW    = 16;
    localparam int unsigned RegIdxW = 4;
    localparam int unsigned DataW   = 32;
    localparam int unsigned IdW     = 8;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    localparam logic [IdW-1:0] ID_LOW_BYTES = 8'd32;
    localparam logic [IdW-1:0] ID_PAIR_4    = 8'd33;
    localparam logic [IdW-1:0] ID_HI_4      = 8'd34;
    localparam logic [IdW-1:0] ID_LO_4      = 8'd35;
    localparam logic [IdW-1:0] ID_HI_5      = 8'd36;
    localparam logic [IdW-1:0] ID_LO_5      = 8'd37;
    localparam logic [IdW-1:0] ID_PAIR_6    = 8'd38;
    localparam logic [IdW-1:0] ID_PAIR_8    = 8'd39;
    localparam logic [IdW-1:0] ID_PAIR_10   = 8'd40;
    localparam logic [IdW-1:0] ID_PAIR_12   = 8'd41;

    localparam logic [IdW-1:0] NarrowDirectMax = 8'd2;

    typedef logic [NumRegs-1:0][RegW-1:0] bank_t;

    typedef struct packed {
        logic [NumRegs-1:0] we_hi;
        logic [NumRegs-1:0] we_lo;
        bank_t              wdata;
    } wr_cmd_t;

endpackage : arb_pkg

`default_nettype wire

[src/arb_access.sv]
// ----------------------------------------------------------------------------
// arb_access: access decoder
// Decodes one operation against the current bank contents into a byte-wise
// write command, the read view and the unsupported flag.
// ----------------------------------------------------------------------------
`default_nettype none

module arb_access (
    input  wire logic [1:0]                 operation,
    input  wire logic [arb_pkg::IdW-1:0]    reg_id,
    input  wire logic [arb_pkg::DataW-1:0]  write_data,
    input  wire arb_pkg::bank_t             bank,
    output arb_pkg::wr_cmd_t                cmd,
    output logic [arb_pkg::DataW-1:0]       read_data,
    output logic                            unsupported
);

    logic                          is_direct;
    logic [arb_pkg::RegIdxW-1:0]   idx;
    arb_pkg::op_t                  op;
    logic [arb_pkg::DataW-1:0]     view;

    assign is_direct = (reg_id < arb_pkg::IdW'(arb_pkg::NumRegs));
    assign idx       = reg_id[arb_pkg::RegIdxW-1:0];
    assign op        = arb_pkg::op_t'(operation);

    always_comb
    begin
        unsupported = 1'b0;
        view        = '0;
        if (is_direct)
        begin
            view = {16'h0000, bank[idx]};
        end
        else
        begin
            unique case (reg_id)
                arb_pkg::ID_LOW_BYTES: view = {16'h0000, bank[0][7:0], bank[1][7:0]};
                arb_pkg::ID_PAIR_4:    view = {bank[4], bank[5]};
                arb_pkg::ID_HI_4:      view = {24'h000000, bank[4][15:8]};
                arb_pkg::ID_LO_4:      view = {24'h000000, bank[4][7:0]};
                arb_pkg::ID_HI_5:      view = {24'h000000, bank[5][15:8]};
                arb_pkg::ID_LO_5:      view = {24'h000000, bank[5][7:0]};
                arb_pkg::ID_PAIR_6:    view = {bank[6], bank[7]};
                arb_pkg::ID_PAIR_8:    view = {bank[8], bank[9]};
                arb_pkg::ID_PAIR_10:   view = {bank[10], bank[11]};
                arb_pkg::ID_PAIR_12:   view = {bank[12], bank[13]};
                default:               unsupported = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        cmd       = '0;
        read_data = '0;
        unique case (op)
            arb_pkg::OP_READ:
            begin
                read_data = view;
            end
            arb_pkg::OP_WRITE:
            begin
                if (is_direct)
                begin
                    cmd.we_hi[idx] = 1'b1;
                    cmd.we_lo[idx] = 1'b1;
                    if (reg_id <= arb_pkg::NarrowDirectMax)
                    begin
                        cmd.wdata[idx] = {8'h00, write_data[7:0]};
                    end
                    else
                    begin
                        cmd.wdata[idx] = write_data[15:0];
                    end
                end
                else
                begin
                    unique case (reg_id)
                        arb_pkg::ID_LOW_BYTES:
                        begin
                            cmd.we_hi[1:0] = 2'b11;
                            cmd.we_lo[1:0] = 2'b11;
                            cmd.wdata[0]   = {8'h00, write_data[15:8]};
                            cmd.wdata[1]   = {8'h00, write_data[7:0]};
                        end
                        arb_pkg::ID_PAIR_4:
                        begin
                            cmd.we_hi[5:4] = 2'b11;
                            cmd.we_lo[5:4] = 2'b11;
                            cmd.wdata[4]   = write_data[31:16];
                            cmd.wdata[5]   = write_data[15:0];
                        end
                        arb_pkg::ID_HI_4:
                        begin
                            cmd.we_hi[4] = 1'b1;
                            cmd.wdata[4] = {write_data[7:0], 8'h00};
                        end
                        arb_pkg::ID_LO_4:
                        begin
                            cmd.we_lo[4] = 1'b1;
                            cmd.wdata[4] = {8'h00, write_data[7:0]};
                        end
                        arb_pkg::ID_HI_5:
                        begin
                            cmd.we_hi[5] = 1'b1;
                            cmd.wdata[5] = {write_data[7:0], 8'h00};
                        end
                        arb_pkg::ID_LO_5:
                        begin
                            cmd.we_lo[5] = 1'b1;
                            cmd.wdata[5] = {8'h00, write_data[7:0]};
                        end
                        arb_pkg::ID_PAIR_6:
                        begin
                            cmd.we_hi[7:6] = 2'b11;
                            cmd.we_lo[7:6] = 2'b11;
                            cmd.wdata[6]   = write_data[31:16];
                            cmd.wdata[7]   = write_data[15:0];
                        end
                        arb_pkg::ID_PAIR_8:
                        begin
                            cmd.we_hi[9:8] = 2'b11;
                            cmd.we_lo[9:8] = 2'b11;
                            cmd.wdata[8]   = write_data[31:16];
                            cmd.wdata[9]   = write_data[15:0];
                        end
                        arb_pkg::ID_PAIR_10:
                        begin
                            cmd.we_hi[11:10] = 2'b11;
                            cmd.we_lo[11:10] = 2'b11;
                            cmd.wdata[10]    = write_data[31:16];
                            cmd.wdata[11]    = write_data[15:0];
                        end
                        arb_pkg::ID_PAIR_12:
                        begin
                            cmd.we_hi[13:12] = 2'b11;
                            cmd.we_lo[13:12] = 2'b11;
                            cmd.wdata[12]    = write_data[31:16];
                            cmd.wdata[13]    = write_data[15:0];
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            arb_pkg::OP_CLEAR:
            begin
                cmd.we_hi = '1;
                cmd.we_lo = '1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule : arb_access

`default_nettype wire

[src/arb_regfile.sv]
// ----------------------------------------------------------------------------
// arb_regfile: register storage
// Fourteen 16-bit flip-flop registers with separate high and low byte
// write enables, cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module arb_regfile (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire arb_pkg::wr_cmd_t  cmd,
    output arb_pkg::bank_t         bank
);

    arb_pkg::bank_t bank_reg;
    arb_pkg::bank_t bank_next;

    always_comb
    begin
        bank_next = bank_reg;
        for (int i = 0; i < arb_pkg::NumRegs; i++)
        begin
            if (wr_en && cmd.we_hi[i])
            begin
                bank_next[i][15:8] = cmd.wdata[i][15:8];
            end
            if (wr_en && cmd.we_lo[i])
            begin
                bank_next[i][7:0] = cmd.wdata[i][7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= '0;
        end
        else
        begin
            bank_reg <= bank_next;
        end
    end

    assign bank = bank_reg;

endmodule : arb_regfile

`default_nettype wire

[src/aliased_register_bank.sv]
// ----------------------------------------------------------------------------
// aliased_register_bank: fourteen 16-bit registers with aliased views
// Input register, one execute step against the flop bank, result register.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is a read, write or clear-all and yields
// exactly one result transfer. The block takes one transfer per cycle while
// the output is not stalled. Each access is latched in the input register,
// then executed against the flop bank into the result register, which
// presents the result. Reads always see every earlier write, and a stalled
// output holds the pipeline without losing transfers.
`default_nettype none

module aliased_register_bank (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  operation,
    input  wire logic [arb_pkg::IdW-1:0]     reg_id,
    input  wire logic [arb_pkg::DataW-1:0]   write_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [arb_pkg::DataW-1:0]        read_data,
    output logic                             unsupported
);

    logic                        in_valid_reg;
    logic [1:0]                  op_reg;
    logic [arb_pkg::IdW-1:0]     id_reg;
    logic [arb_pkg::DataW-1:0]   data_reg;
    logic                        out_valid_reg;
    logic [arb_pkg::DataW-1:0]   read_data_reg;
    logic                        unsupported_reg;

    logic                        exec_ready;
    logic                        exec_fire;
    arb_pkg::bank_t              bank;
    arb_pkg::wr_cmd_t            cmd;
    logic [arb_pkg::DataW-1:0]   read_data_next;
    logic                        unsupported_next;

    assign exec_ready = !out_valid_reg || out_ready;
    assign exec_fire  = in_valid_reg && exec_ready;
    assign in_ready   = !in_valid_reg || exec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (exec_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= operation;
            id_reg   <= reg_id;
            data_reg <= write_data;
        end
        if (exec_fire)
        begin
            read_data_reg   <= read_data_next;
            unsupported_reg <= unsupported_next;
        end
    end

    arb_access u_access (
        .operation   (op_reg),
        .reg_id      (id_reg),
        .write_data  (data_reg),
        .bank        (bank),
        .cmd         (cmd),
        .read_data   (read_data_next),
        .unsupported (unsupported_next)
    );

    arb_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (exec_fire),
        .cmd   (cmd),
        .bank  (bank)
    );

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign unsupported = unsupported_reg;

    a_clear_zeroes_bank: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (op_reg == arb_pkg::OP_CLEAR) |=> (bank == '0))
        else $error("Clear did not zero the register bank.");

    a_nonread_returns_zero: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (op_reg != arb_pkg::OP_READ) |=> (read_data == '0))
        else $error("A non-read transfer returned nonzero data.");

    a_unsupported_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && unsupported_next && (op_reg != arb_pkg::OP_CLEAR)
        |=> $stable(bank))
        else $error("An unsupported ID changed the register bank.");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("Input accepted while the pipeline was full and stalled.");

endmodule : aliased_register_bank

`default_nettype wire
